// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion clocked on clk_i, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Same, but also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);
`endif

// ----- rtl/core/bbsp_pkg.sv -----
// Package with types and constants of the shortest-path search block.
`default_nettype none
package bbsp_pkg;
  localparam int MaxNodes = 64;
  localparam int NodeBits = 6;
  localparam int CntBits = 7;
  localparam int WeightBits = 16;
  localparam int CostBits = 28;
  localparam int OutCostBits = 27;
  localparam int AdjBits = 2 * NodeBits;
  localparam logic [CostBits-1:0] SumCap = 28'h0FFFFFE;
  localparam logic [WeightBits-1:0] WMax = 16'h7FFF;

  localparam logic [1:0] RegNodeCount = 2'd0;
  localparam logic [1:0] RegSource = 2'd1;
  localparam logic [1:0] RegDest = 2'd2;

  typedef enum logic [3:0] {
    StIdle,
    StInit,
    StTop,
    StRead,
    StEval,
    StCopy,
    StEmit,
    StEmitWait,
    StNone
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic init;      // clear visited, set bound, push source
    logic top_rd;    // fetch top-of-stack entries
    logic adj_rd;    // issue adjacency read
    logic eval;      // evaluate candidate
    logic copy_step; // copy one route entry
    logic emit_ld;   // load output register from route
    logic none_ld;   // load not-found result
  } cmd_t;

  // Datapath status back to the controller.
  typedef struct packed {
    logic trivial;   // search ends with empty or one-node result
    logic empty;     // stack drained
    logic exhausted; // neighbor index past limit
    logic keep;      // candidate hits destination
    logic copy_done;
    logic have_route;
    logic emit_last;
    logic out_busy;
  } stat_t;
endpackage
`default_nettype wire

// ----- rtl/core/bbsp_ctrl.sv -----
// Controller state machine of the search block.
`default_nettype none
`include "assert_macros.svh"
module bbsp_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire bbsp_pkg::stat_t stat_i,
  output bbsp_pkg::cmd_t     cmd_o,
  output logic               idle_o
);
  bbsp_pkg::state_e state_q, state_d;

  // Advance the state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbsp_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bbsp_pkg::StIdle: if (start_i) state_d = bbsp_pkg::StInit;
      bbsp_pkg::StInit: begin
        if (stat_i.trivial) state_d = stat_i.have_route ? bbsp_pkg::StEmit : bbsp_pkg::StNone;
        else state_d = bbsp_pkg::StTop;
      end
      bbsp_pkg::StTop: begin
        if (stat_i.empty) state_d = stat_i.have_route ? bbsp_pkg::StEmit : bbsp_pkg::StNone;
        else state_d = bbsp_pkg::StRead;
      end
      bbsp_pkg::StRead: state_d = bbsp_pkg::StEval;
      bbsp_pkg::StEval: state_d = stat_i.keep ? bbsp_pkg::StCopy : bbsp_pkg::StTop;
      bbsp_pkg::StCopy: if (stat_i.copy_done) state_d = bbsp_pkg::StTop;
      bbsp_pkg::StEmit: if (!stat_i.out_busy) state_d = bbsp_pkg::StEmitWait;
      bbsp_pkg::StEmitWait: begin
        if (stat_i.emit_last) state_d = bbsp_pkg::StIdle;
        else state_d = bbsp_pkg::StEmit;
      end
      bbsp_pkg::StNone: if (!stat_i.out_busy) state_d = bbsp_pkg::StIdle;
      default: state_d = bbsp_pkg::StIdle;
    endcase
  end

  // Commands.
  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      bbsp_pkg::StInit: cmd_o.init = 1'b1;
      bbsp_pkg::StTop: cmd_o.top_rd = 1'b1;
      bbsp_pkg::StRead: cmd_o.adj_rd = 1'b1;
      bbsp_pkg::StEval: cmd_o.eval = 1'b1;
      bbsp_pkg::StCopy: cmd_o.copy_step = 1'b1;
      bbsp_pkg::StEmit: cmd_o.emit_ld = !stat_i.out_busy;
      bbsp_pkg::StNone: cmd_o.none_ld = !stat_i.out_busy;
      default: ;
    endcase
  end

  assign idle_o = (state_q == bbsp_pkg::StIdle);

  `ASSERT_CLK(a_start_idle, start_i |-> state_q == bbsp_pkg::StIdle, "start while busy")
  `ASSERT_CLK(a_emit_ready, cmd_o.emit_ld |-> !stat_i.out_busy, "emit over busy output")
  `ASSERT_CLK(a_eval_after_read, state_q == bbsp_pkg::StEval |-> $past(state_q) == bbsp_pkg::StRead,
              "eval without read")
endmodule
`default_nettype wire

// ----- rtl/core/bbsp_datapath.sv -----
// Datapath: adjacency memory, search stacks, best route and output register.
`default_nettype none
`include "assert_macros.svh"
module bbsp_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire bbsp_pkg::cmd_t                      cmd_i,
  output bbsp_pkg::stat_t                          stat_o,
  // load port
  input  wire logic                                wr_en_i,
  input  wire logic [bbsp_pkg::NodeBits-1:0]       row_i,
  input  wire logic [bbsp_pkg::NodeBits-1:0]       col_i,
  input  wire logic signed [bbsp_pkg::WeightBits-1:0] weight_i,
  // configuration
  input  wire logic [bbsp_pkg::CntBits-1:0]        node_count_i,
  input  wire logic [bbsp_pkg::NodeBits-1:0]       source_i,
  input  wire logic [bbsp_pkg::NodeBits-1:0]       dest_i,
  // result
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic                                     found_o,
  output logic [bbsp_pkg::NodeBits-1:0]            node_o,
  output logic [bbsp_pkg::NodeBits-1:0]            position_o,
  output logic [bbsp_pkg::OutCostBits-1:0]         path_cost_o,
  output logic                                     last_o
);
  localparam int NB = bbsp_pkg::NodeBits;
  localparam int CB = bbsp_pkg::CostBits;
  localparam int KB = bbsp_pkg::CntBits;
  localparam int D = bbsp_pkg::MaxNodes;

  logic signed [bbsp_pkg::WeightBits-1:0] adj_mem [1 << bbsp_pkg::AdjBits];
  logic [NB-1:0] path_mem [D];
  logic [KB-1:0] nn_mem [D];
  logic [CB-1:0] cost_mem [D];
  logic [NB-1:0] best_mem [D];

  logic [CB-1:0] sum_q;
  logic [D-1:0] visited_q;
  logic [KB-1:0] top_q;        // stack depth count, top entry is top_q-1
  logic [KB-1:0] best_len_q;
  logic [CB-1:0] best_cost_q;
  logic [KB-1:0] lim_q;
  logic [NB-1:0] x_q;
  logic [KB-1:0] i_q;
  logic [CB-1:0] c_top_q;
  logic signed [bbsp_pkg::WeightBits-1:0] w_q;
  logic [KB-1:0] cp_q;
  logic [NB-1:0] cp_data_q;
  logic [KB-1:0] em_q;

  logic [NB-1:0] top_idx;
  logic [KB-1:0] lim_c;
  logic [CB-1:0] cand;
  logic cand_ok;
  logic trivial_c;
  logic same_c;
  logic [CB:0] sum_ext;

  assign top_idx = NB'(top_q - 7'd1);
  assign lim_c = (node_count_i > 7'(D)) ? 7'(D) : node_count_i;
  assign trivial_c = (lim_c == '0) || ({1'b0, source_i} >= lim_c) ||
                     ({1'b0, dest_i} >= lim_c) || (source_i == dest_i);
  assign same_c = (lim_c != '0) && ({1'b0, source_i} < lim_c) &&
                  ({1'b0, dest_i} < lim_c) && (source_i == dest_i);
  assign cand = c_top_q + CB'(unsigned'(w_q));
  assign cand_ok = !visited_q[i_q[NB-1:0]] && !w_q[bbsp_pkg::WeightBits-1] &&
                   (cand < best_cost_q) && (top_q < lim_q);
  assign sum_ext = {1'b0, sum_q} + {{(CB + 1 - bbsp_pkg::WeightBits){1'b0}}, weight_i};

  // Store entries, read adjacency weights and accumulate the sum of non-negative weights.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      adj_mem[{row_i, col_i}] <= weight_i;
    end
    if (cmd_i.adj_rd) begin
      w_q <= adj_mem[{x_q, i_q[NB-1:0]}];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (wr_en_i && !weight_i[bbsp_pkg::WeightBits-1]) begin
      sum_q <= (sum_ext > {1'b0, bbsp_pkg::SumCap}) ? bbsp_pkg::SumCap : sum_ext[CB-1:0];
    end
  end

  // Stack memories: source push, top fetch, push, neighbor advance and route copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.init) begin
      path_mem[0] <= source_i;
      cost_mem[0] <= '0;
      nn_mem[0] <= '0;
    end
    if (cmd_i.top_rd) begin
      x_q <= path_mem[top_idx];
      i_q <= nn_mem[top_idx];
      c_top_q <= cost_mem[top_idx];
    end
    if (cmd_i.adj_rd) begin
      nn_mem[top_idx] <= i_q + 7'd1;
    end
    if (cmd_i.eval && cand_ok) begin
      path_mem[top_q[NB-1:0]] <= i_q[NB-1:0];
      cost_mem[top_q[NB-1:0]] <= cand;
      nn_mem[top_q[NB-1:0]] <= '0;
    end
    if (cmd_i.copy_step) begin
      cp_data_q <= path_mem[cp_q[NB-1:0]];
    end
    if (cmd_i.copy_step && cp_q != '0) begin
      best_mem[NB'(cp_q - 7'd1)] <= cp_data_q;
    end
    if (cmd_i.init && same_c) begin
      best_mem[0] <= source_i;
    end
  end

  logic exhausted;
  assign exhausted = (cmd_i.top_rd) ? 1'b0 : (i_q >= lim_q);

  // Search control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '0;
      visited_q <= '0;
      best_len_q <= '0;
      best_cost_q <= '0;
      lim_q <= 7'd1;
      cp_q <= '0;
    end else begin
      if (cmd_i.init) begin
        lim_q <= lim_c;
        visited_q <= trivial_c ? '0 : (D'(1) << source_i);
        best_cost_q <= same_c ? '0 : sum_q + 28'd1;
        best_len_q <= same_c ? 7'd1 : '0;
        top_q <= trivial_c ? '0 : 7'd1;
      end
      if (cmd_i.adj_rd && i_q >= lim_q) begin
        // pop: exhausted neighbors
        visited_q[x_q] <= 1'b0;
        top_q <= top_q - 7'd1;
      end
      if (cmd_i.eval && i_q < lim_q && cand_ok) begin
        if (i_q[NB-1:0] == dest_i) begin
          best_cost_q <= cand;
          best_len_q <= top_q + 7'd1;
          cp_q <= '0;
        end else begin
          visited_q[i_q[NB-1:0]] <= 1'b1;
          top_q <= top_q + 7'd1;
        end
      end
      if (cmd_i.copy_step) begin
        cp_q <= cp_q + 7'd1;
      end
    end
  end

  // Output register: route entries or not-found.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
      em_q <= '0;
    end else begin
      out_valid_o <= cmd_i.emit_ld || cmd_i.none_ld || (out_valid_o && !out_ready_i);
      if (cmd_i.init) em_q <= '0;
      if (cmd_i.emit_ld) em_q <= em_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_ld) begin
      found_o <= 1'b1;
      node_o <= best_mem[em_q[NB-1:0]];
      position_o <= em_q[NB-1:0];
      path_cost_o <= best_cost_q[bbsp_pkg::OutCostBits-1:0];
      last_o <= (em_q + 7'd1 == best_len_q);
    end else if (cmd_i.none_ld) begin
      found_o <= 1'b0;
      node_o <= '0;
      position_o <= '0;
      path_cost_o <= '0;
      last_o <= 1'b1;
    end
  end

  // The copy moves path_mem[0..len-1] into best_mem, each entry written from cp_data_q in the cycle after its read.
  assign stat_o.trivial = trivial_c;
  assign stat_o.empty = (top_q == '0);
  assign stat_o.exhausted = exhausted;
  assign stat_o.keep = cand_ok && (i_q < lim_q) && (i_q[NB-1:0] == dest_i);
  assign stat_o.copy_done = (cp_q == best_len_q);
  assign stat_o.have_route = cmd_i.init ? same_c : (best_len_q != '0);
  assign stat_o.emit_last = (em_q == best_len_q);
  assign stat_o.out_busy = out_valid_o && !out_ready_i;

  `ASSERT_CLK(a_push_bound, cmd_i.eval && cand_ok && i_q < lim_q |-> top_q < lim_q,
              "push beyond node limit")
  `ASSERT_CLK(a_best_drops, stat_o.keep && cmd_i.eval |=> best_cost_q < $past(best_cost_q),
              "best cost not lowered")
  `ASSERT_ALWAYS(a_depth, top_q <= 7'(D), "stack depth overflow")
endmodule
`default_nettype wire

// ----- rtl/core/branch_bound_shortest_simple_path.sv -----
// After the last entry the search walks the graph depth first, each neighbor tried by a
// stack read, an adjacency read and an evaluate step, plus a route copy per improvement;
// then the route entries are emitted in order. Loading takes one entry per cycle while idle.
// The adjacency memory has no reset; weight sum, bounds and control clear on rst_ni.
// Top level of the shortest simple path search block.
`default_nettype none
module branch_bound_shortest_simple_path (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [5:0]  row_i,
  input  wire logic [5:0]  col_i,
  input  wire logic signed [15:0] weight_i,
  input  wire logic        last_entry_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [6:0]  cfg_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             found_o,
  output logic [5:0]       node_o,
  output logic [5:0]       position_o,
  output logic [26:0]      path_cost_o,
  output logic             last_o
);
  bbsp_pkg::cmd_t cmd;
  bbsp_pkg::stat_t stat;
  logic idle;
  logic acc;
  logic [6:0] node_count_q;
  logic [5:0] source_q, dest_q;

  assign in_ready_o = idle;
  assign cfg_ready_o = 1'b1;
  assign acc = in_valid_i && in_ready_o;

  // Hold configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 7'd1;
      source_q <= '0;
      dest_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bbsp_pkg::RegNodeCount: node_count_q <= cfg_data_i;
        bbsp_pkg::RegSource: source_q <= cfg_data_i[5:0];
        bbsp_pkg::RegDest: dest_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  bbsp_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(acc && last_entry_i),
    .stat_i(stat),
    .cmd_o(cmd),
    .idle_o(idle)
  );

  bbsp_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i(cmd), .stat_o(stat),
    .wr_en_i(acc), .row_i, .col_i, .weight_i,
    .node_count_i(node_count_q), .source_i(source_q), .dest_i(dest_q),
    .out_valid_o, .out_ready_i, .found_o, .node_o, .position_o, .path_cost_o, .last_o
  );
endmodule
`default_nettype wire

// ----- dv/branch_bound_shortest_simple_path_test.sv -----
// Testbench for the shortest simple path search block.
`timescale 1ns / 1ps
`default_nettype none
module branch_bound_shortest_simple_path_test;

  typedef struct {
    logic        found;
    logic [5:0]  node;
    logic [5:0]  position;
    logic [26:0] path_cost;
    logic        last;
  } route_step_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic [5:0] row_i = '0;
  logic [5:0] col_i = '0;
  logic signed [15:0] weight_i = '0;
  logic last_entry_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [6:0] cfg_data_i = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o, cfg_ready_o, out_valid_o, found_o, last_o;
  logic [5:0] node_o, position_o;
  logic [26:0] path_cost_o;

  branch_bound_shortest_simple_path u_top (.*);

  // Predictor state
  int          adj_w [bbsp_pkg::MaxNodes][bbsp_pkg::MaxNodes];
  int unsigned wsum;
  int unsigned count_reg, src_reg, dst_reg;
  route_step_t route_q [$];
  int          n_fail;
  bit          no_idle;
  int          n_sent;

  initial forever #5 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("Mismatches found");
    $finish;
  end

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    n_fail++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 70) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Depth-first branch and bound over the loaded matrix; queue the best route.
  function automatic void predict_route();
    int unsigned lim, best_cost, best_len, c;
    int top, x, i, w, k;
    bit [63:0] seen;
    int path [bbsp_pkg::MaxNodes];
    int nxt [bbsp_pkg::MaxNodes];
    int unsigned cst [bbsp_pkg::MaxNodes];
    int best [bbsp_pkg::MaxNodes];
    route_step_t s;
    lim = (count_reg > bbsp_pkg::MaxNodes) ? bbsp_pkg::MaxNodes : count_reg;
    best_len = 0;
    best_cost = wsum + 1;
    seen = '0;
    if (lim != 0 && src_reg < lim && dst_reg < lim) begin
      if (src_reg == dst_reg) begin
        best[0] = src_reg;
        best_len = 1;
        best_cost = 0;
      end else begin
        path[0] = src_reg;
        cst[0] = 0;
        nxt[0] = 0;
        seen[src_reg] = 1'b1;
        top = 0;
        while (top >= 0) begin
          x = path[top];
          i = nxt[top];
          if (i >= lim) begin
            seen[x] = 1'b0;
            top--;
            continue;
          end
          nxt[top] = i + 1;
          w = adj_w[x][i];
          if (seen[i] || w < 0) continue;
          c = cst[top] + w;
          if (c >= best_cost || top + 1 >= lim) continue;
          path[top+1] = i;
          cst[top+1] = c;
          if (i == dst_reg) begin
            for (k = 0; k <= top + 1; k++) best[k] = path[k];
            best_len = top + 2;
            best_cost = c;
            continue;
          end
          seen[i] = 1'b1;
          nxt[top+1] = 0;
          top++;
        end
      end
    end
    if (best_len == 0) begin
      s = '{1'b0, 6'd0, 6'd0, 27'd0, 1'b1};
      route_q.push_back(s);
    end else begin
      for (k = 0; k < best_len; k++) begin
        s.found = 1'b1;
        s.node = 6'(best[k]);
        s.position = 6'(k);
        s.path_cost = best_cost[26:0];
        s.last = (k + 1 == best_len);
        route_q.push_back(s);
      end
    end
  endfunction

  // Send one matrix entry; valid stays high across back-to-back requests.
  task automatic send_entry(input int r, input int c, input logic [15:0] w, input bit l);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_i <= 6'(r);
    col_i <= 6'(c);
    weight_i <= w;
    last_entry_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
    // Update the matrix copy and the running sum
    if (w[15]) begin
      adj_w[r][c] = -1;
    end else begin
      adj_w[r][c] = w;
      wsum = wsum + w;
      if (wsum > bbsp_pkg::SumCap) wsum = bbsp_pkg::SumCap;
    end
    if (l) predict_route();
  endtask

  // Drop valid and wait until every queued result has come back.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (route_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(input int cnt, input int s, input int d);
    int v [3];
    int k;
    v = '{cnt, s, d};
    for (k = 0; k < 3; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= (k == 0) ? bbsp_pkg::RegNodeCount :
                     (k == 1) ? bbsp_pkg::RegSource : bbsp_pkg::RegDest;
      cfg_data_i <= 7'(v[k]);
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    count_reg = cnt;
    src_reg = s;
    dst_reg = d;
  endtask

  // Load a full n by n block in random order, last entry starts the search.
  task automatic send_graph(input int n, input int pct_edge);
    int idx [$];
    int k, e;
    logic [15:0] w;
    for (k = 0; k < n * n; k++) idx.push_back(k);
    idx.shuffle();
    for (k = 0; k < idx.size(); k++) begin
      e = $urandom_range(0, 99);
      if (e >= pct_edge) w = ($urandom_range(0, 3) == 0) ? 16'h8000 | 16'($urandom) : 16'hFFFF;
      else if (e < 5) w = 16'h7FFF - 16'($urandom_range(0, 3));
      else if (e < 10) w = 16'($urandom) & 16'h7FFF;
      else w = 16'($urandom_range(0, 20));
      send_entry(idx[k] / n, idx[k] % n, w, k == idx.size() - 1);
    end
  endtask

  task automatic test_corner_configs();
    write_cfg(1, 0, 0);
    send_entry(0, 0, 16'd5, 1'b1);
    settle();
    write_cfg(0, 0, 0);
    send_entry(0, 0, 16'hFFFF, 1'b1);
    settle();
    write_cfg(2, 0, 3);
    send_entry(0, 1, 16'd1, 1'b0);
    send_entry(1, 0, 16'd1, 1'b0);
    send_entry(1, 1, 16'hFFFF, 1'b0);
    send_entry(0, 0, 16'hFFFF, 1'b1);
    settle();
  endtask

  task automatic test_tie_and_prune();
    logic [15:0] w [16];
    int k;
    for (k = 0; k < 16; k++) w[k] = 16'hFFFF;
    w[0*4+1] = 16'd2;  w[1*4+3] = 16'd3;  w[0*4+2] = 16'd4;
    w[2*4+3] = 16'd1;  w[0*4+3] = 16'hFFFE; w[3*4+0] = 16'h8000;
    w[1*4+2] = 16'h7FFF;
    write_cfg(4, 0, 3);
    for (k = 0; k < 16; k++) send_entry(k / 4, k % 4, w[k], k == 15);
    settle();
    write_cfg(4, 3, 0);
    send_entry(0, 0, 16'hFFFF, 1'b1);
    settle();
  endtask

  // Twelve-node matrix: a chain from node 0 to node 11, every node on the route.
  task automatic test_full_matrix();
    int r, c;
    logic [15:0] w;
    write_cfg(12, 0, 11);
    for (r = 0; r < 12; r++)
      for (c = 0; c < 12; c++) begin
        if (c == r + 1) w = 16'($urandom_range(1, 32767));
        else if (r == 11 && c == 10) w = 16'h7FFF;
        else w = 16'hFFFF;
        send_entry(r, c, w, r == 11 && c == 11);
      end
    settle();
    write_cfg(12, 11, 0);
    send_entry(11, 11, 16'hFFFF, 1'b1);
    settle();
    // Node count above the node limit, one-node route
    write_cfg(127, 40, 40);
    send_entry(11, 11, 16'hFFFF, 1'b1);
    settle();
  endtask

  task automatic test_random_graphs();
    int n, k, start;
    start = n_sent;
    while (n_sent - start < 150) begin
      no_idle = ($urandom_range(0, 5) == 0);
      n = $urandom_range(1, 6);
      if ($urandom_range(0, 9) == 0)
        write_cfg(n, $urandom_range(0, 63), $urandom_range(0, 63));
      else
        write_cfg(n, $urandom_range(0, n - 1), $urandom_range(0, n - 1));
      if ($urandom_range(0, 6) == 0) begin
        // Noise: stray entries anywhere, rows and columns drawn from the whole 64 by 64 matrix
        for (k = 0; k < 6; k++)
          send_entry($urandom_range(0, 63), $urandom_range(0, 63), 16'($urandom), k == 5);
      end else begin
        send_graph(n, $urandom_range(30, 90));
      end
      settle();
    end
    no_idle = 1'b0;
  endtask

  // Result side stalls
  int stall_left;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 99) < 20) begin
      stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest queued route step
  always @(posedge clk_i) begin
    route_step_t exp_s;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (route_q.size() == 0) begin
        report($sformatf("unexpected result node=%0d pos=%0d", node_o, position_o));
      end else begin
        exp_s = route_q.pop_front();
        if (found_o !== exp_s.found)
          report($sformatf("found %0b, want %0b", found_o, exp_s.found));
        if (node_o !== exp_s.node)
          report($sformatf("node %0d, want %0d", node_o, exp_s.node));
        if (position_o !== exp_s.position)
          report($sformatf("position %0d, want %0d", position_o, exp_s.position));
        if (path_cost_o !== exp_s.path_cost)
          report($sformatf("path_cost %0d, want %0d", path_cost_o, exp_s.path_cost));
        if (last_o !== exp_s.last)
          report($sformatf("last %0b, want %0b", last_o, exp_s.last));
      end
    end
  end

  initial begin
    n_fail = 0;
    n_sent = 0;
    wsum = 0;
    no_idle = 1'b0;
    stall_left = 0;
    count_reg = 1;
    src_reg = 0;
    dst_reg = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corner_configs();
    test_tie_and_prune();
    test_full_matrix();
    test_random_graphs();
    if (n_fail == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- branch_bound_shortest_simple_path.f -----
+incdir+rtl/core
rtl/core/bbsp_pkg.sv
rtl/core/bbsp_ctrl.sv
rtl/core/bbsp_datapath.sv
rtl/core/branch_bound_shortest_simple_path.sv
dv/branch_bound_shortest_simple_path_test.sv
